// ----- design/pip_pkg.sv -----
// shared constants and types for the winding-number point-in-polygon block
`timescale 1ns / 1ps
package pip_pkg;

  // default sizes handed to the top level
  localparam int MAX_VERTS_DEF  = 256;
  localparam int COORD_BITS_DEF = 16;

  // request codes on the input channel
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // result formatting
  localparam int MIN_POLY = 3;
  localparam int WIND_W   = 9;
  localparam int WIND_MAX = 255;
  localparam int WIND_MIN = -256;

  // command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

endpackage

// ----- design/pip_if.sv -----
// channel interfaces: request input and query result output
`timescale 1ns / 1ps
interface pip_in_if #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, output req_type, output coord_x, output coord_y,
                  input ready);
  modport sink   (input valid, input req_type, input coord_x, input coord_y,
                  output ready);
endinterface

interface pip_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 inside_res;
  logic signed [pip_pkg::WIND_W-1:0]    winding;
  logic                                 too_few;

  modport source (output valid, output inside_res, output winding, output too_few,
                  input ready);
  modport sink   (input valid, input inside_res, input winding, input too_few,
                  output ready);
endinterface

// ----- design/pip_front.sv -----
// front end: decodes requests and queues them as commands for the back end
`timescale 1ns / 1ps
module pip_front #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pip_in_if.sink                       in_ch,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output pip_pkg::op_t                 cmd_op,
  output logic signed [COORD_BITS-1:0] cmd_x,
  output logic signed [COORD_BITS-1:0] cmd_y
);

  localparam int CW = pip_pkg::FIFO_AW + 1;

  pip_pkg::op_t                 op_q   [pip_pkg::FIFO_DEPTH];
  logic signed [COORD_BITS-1:0] x_q    [pip_pkg::FIFO_DEPTH];
  logic signed [COORD_BITS-1:0] y_q    [pip_pkg::FIFO_DEPTH];
  logic [pip_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [pip_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [CW-1:0]                cnt_r;
  logic                         in_xfer;
  logic                         push;
  logic                         pop;
  pip_pkg::op_t                 dec_op;

  // unknown request code is taken and dropped
  always_comb begin
    dec_op = pip_pkg::OP_CLEAR;
    push   = 1'b0;
    case (in_ch.req_type)
      pip_pkg::REQ_CLEAR: begin
        dec_op = pip_pkg::OP_CLEAR;
        push   = in_xfer;
      end
      pip_pkg::REQ_APPEND: begin
        dec_op = pip_pkg::OP_APPEND;
        push   = in_xfer;
      end
      pip_pkg::REQ_QUERY: begin
        dec_op = pip_pkg::OP_QUERY;
        push   = in_xfer;
      end
      default: begin
        dec_op = pip_pkg::OP_CLEAR;
        push   = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = (cnt_r != CW'(pip_pkg::FIFO_DEPTH));
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd_op      = op_q[rd_ptr_r];
  assign cmd_x       = x_q[rd_ptr_r];
  assign cmd_y       = y_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + pip_pkg::FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + pip_pkg::FIFO_AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r] <= dec_op;
      x_q[wr_ptr_r]  <= in_ch.coord_x;
      y_q[wr_ptr_r]  <= in_ch.coord_y;
    end
  end

endmodule

// ----- design/pip_back.sv -----
// back end: vertex store, edge walk pipeline and result register
`timescale 1ns / 1ps
module pip_back #(
  parameter int MAX_VERTS  = pip_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  pip_pkg::op_t                 cmd_op,
  input  logic signed [COORD_BITS-1:0] cmd_x,
  input  logic signed [COORD_BITS-1:0] cmd_y,
  pip_out_if.source                    out_ch
);

  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int AW    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = CNT_W + 1;
  localparam int SW    = (ACC_W > pip_pkg::WIND_W + 1) ? ACC_W : pip_pkg::WIND_W + 1;

  logic [2*COORD_BITS-1:0] mem [MAX_VERTS];

  pip_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             n_r;
  logic [CNT_W-1:0]             k_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic                         take;
  logic                         is_query;
  logic                         last;
  logic [AW-1:0]                rd_addr;
  logic                         pipe_busy;

  // read stage
  logic                    rv_r, rfirst_r;
  logic [2*COORD_BITS-1:0] rd_data_r;
  logic [2*COORD_BITS-1:0] prev_r;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;

  // edge stage
  logic                 e_v_r, e_up_r, e_dn_r;
  logic signed [DW-1:0] dxe_r, dyp_r, dxp_r, dye_r;

  // product stage
  logic                 m_v_r, m_up_r, m_dn_r;
  logic signed [PW-1:0] l_r, r_r;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [SW-1:0]    acc_ext;
  logic signed [SW-1:0]    wsat;

  logic                              out_valid_r;
  logic                              inside_r;
  logic signed [pip_pkg::WIND_W-1:0] wind_r;
  logic                              too_few_r;

  assign is_query  = (cmd_op == pip_pkg::OP_QUERY);
  assign take      = cmd_valid && (state_r == pip_pkg::ST_IDLE) && (!is_query || !out_valid_r);
  assign cmd_ready = take;
  assign last      = (k_r == n_r);
  // one extra read of entry zero closes the polygon
  assign rd_addr   = last ? '0 : k_r[AW-1:0];
  assign pipe_busy = rv_r || e_v_r || m_v_r;

  assign ax = $signed(prev_r[2*COORD_BITS-1:COORD_BITS]);
  assign ay = $signed(prev_r[COORD_BITS-1:0]);
  assign bx = $signed(rd_data_r[2*COORD_BITS-1:COORD_BITS]);
  assign by = $signed(rd_data_r[COORD_BITS-1:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pip_pkg::ST_IDLE: begin
        if (take && is_query && (cnt_r >= CNT_W'(pip_pkg::MIN_POLY)))
          state_nxt = pip_pkg::ST_WALK;
      end
      pip_pkg::ST_WALK: begin
        if (last) state_nxt = pip_pkg::ST_DRAIN;
      end
      pip_pkg::ST_DRAIN: begin
        if (!pipe_busy) state_nxt = pip_pkg::ST_IDLE;
      end
      default: state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  // saturate the count to the result width
  always_comb begin
    acc_ext = SW'(acc_r);
    if (acc_ext > SW'(pip_pkg::WIND_MAX))      wsat = SW'(pip_pkg::WIND_MAX);
    else if (acc_ext < SW'(pip_pkg::WIND_MIN)) wsat = SW'(pip_pkg::WIND_MIN);
    else                                       wsat = acc_ext;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pip_pkg::ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      rv_r        <= 1'b0;
      e_v_r       <= 1'b0;
      m_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= (state_r == pip_pkg::ST_WALK);
      e_v_r   <= rv_r && !rfirst_r;
      m_v_r   <= e_v_r;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (take) begin
        case (cmd_op)
          pip_pkg::OP_CLEAR:  cnt_r <= '0;
          pip_pkg::OP_APPEND: begin
            if (cnt_r < CNT_W'(MAX_VERTS)) cnt_r <= cnt_r + CNT_W'(1);
          end
          pip_pkg::OP_QUERY: begin
            k_r <= '0;
            if (cnt_r < CNT_W'(pip_pkg::MIN_POLY)) out_valid_r <= 1'b1;
          end
          default: cnt_r <= cnt_r;
        endcase
      end
      if (state_r == pip_pkg::ST_WALK) k_r <= k_r + CNT_W'(1);
      if ((state_r == pip_pkg::ST_DRAIN) && !pipe_busy) out_valid_r <= 1'b1;
    end
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (take && (cmd_op == pip_pkg::OP_APPEND) && (cnt_r < CNT_W'(MAX_VERTS)))
      mem[cnt_r[AW-1:0]] <= {cmd_x, cmd_y};
    if (state_r == pip_pkg::ST_WALK)
      rd_data_r <= mem[rd_addr];
  end

  // edge pipeline and accumulator
  always_ff @(posedge clk) begin
    if (take && is_query) begin
      n_r   <= cnt_r;
      px_r  <= cmd_x;
      py_r  <= cmd_y;
      acc_r <= '0;
    end
    rfirst_r <= (k_r == '0);
    if (rv_r) prev_r <= rd_data_r;

    dxe_r  <= DW'(bx) - DW'(ax);
    dyp_r  <= DW'(py_r) - DW'(ay);
    dxp_r  <= DW'(px_r) - DW'(ax);
    dye_r  <= DW'(by) - DW'(ay);
    e_up_r <= (ay <= py_r) && (by > py_r);
    e_dn_r <= (ay > py_r) && (by <= py_r);

    l_r    <= dxe_r * dyp_r;
    r_r    <= dxp_r * dye_r;
    m_up_r <= e_up_r;
    m_dn_r <= e_dn_r;

    if (m_v_r && m_up_r && (l_r > r_r)) acc_r <= acc_r + ACC_W'(1);
    if (m_v_r && m_dn_r && (l_r < r_r)) acc_r <= acc_r - ACC_W'(1);

    if (take && is_query) begin
      inside_r  <= 1'b0;
      wind_r    <= '0;
      too_few_r <= 1'b1;
    end
    if ((state_r == pip_pkg::ST_DRAIN) && !pipe_busy) begin
      inside_r  <= (wsat != '0);
      wind_r    <= wsat[pip_pkg::WIND_W-1:0];
      too_few_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = inside_r;
  assign out_ch.winding    = wind_r;
  assign out_ch.too_few    = too_few_r;

endmodule

// ----- design/point_in_polygon_winding.sv -----
// top level of the winding-number point-in-polygon block
//
//  channel   dir  payload                           role
//  in_ch     in   req_type, coord_x, coord_y        clear, append vertex or query point
//  out_ch    out  inside_res, winding, too_few      one result per query
//
// clear and append are handled by the back end when taken from idle; a query of
// n >= 3 vertices walks its edges through the single read port of the vertex
// store (one edge per cycle through read, difference, multiply and compare stages)
// reset zeroes the vertex count but not the store; store entries are written by appends
// a four-entry command queue keeps accepting requests, until it is full, while a
// query walks or a result waits in the output register
`timescale 1ns / 1ps
module point_in_polygon_winding #(
  parameter int MAX_VERTS  = pip_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pip_in_if.sink    in_ch,
  pip_out_if.source out_ch
);

  // command path between decode and the edge walker
  logic                         cmd_valid;
  logic                         cmd_ready;
  pip_pkg::op_t                 cmd_op;
  logic signed [COORD_BITS-1:0] cmd_x;
  logic signed [COORD_BITS-1:0] cmd_y;

  // front: decode requests, drop unknown codes, queue commands
  pip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd_op),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y)
  );

  // back: vertex store, edge walk and result register
  pip_back #(
    .MAX_VERTS  (MAX_VERTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd_op),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .out_ch    (out_ch)
  );

endmodule
